### design/rlp_pkg.sv
// ----------------------------------------------------------------------------
// rlp_pkg: shared types and constants for the request line parser
// Status and kind codes, the result layout and keyword lookup helpers.
// ----------------------------------------------------------------------------
package rlp_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_MALFORMED     = 3'd1,
    ST_UNKNOWN_TYPE  = 3'd2,
    ST_MISSING_NAME  = 3'd3,
    ST_INVALID_NAME  = 3'd4,
    ST_MISSING_COUNT = 3'd5,
    ST_INVALID_COUNT = 3'd6
  } status_t;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_GET    = 2'd1,
    KIND_PUT    = 2'd2,
    KIND_HEALTH = 2'd3
  } kind_t;

  // Keyword slots in the match flags
  localparam int KW_GET    = 0;
  localparam int KW_PUT    = 1;
  localparam int KW_HEALTH = 2;
  localparam int NUM_KW    = 3;

  // ASCII codes used by the parser
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  // Output beat layout, first field in the high bits
  typedef struct packed {
    logic [12:0] name_length;
    logic [11:0] name_offset;
    logic [63:0] byte_count;
    kind_t       request_kind;
    status_t     status;
  } result_t;

  localparam int RESULT_BITS = $bits(result_t);
  localparam int OUT_BYTES   = (RESULT_BITS + 7) / 8;
  localparam int OUT_BITS    = OUT_BYTES * 8;

  // Keyword length per slot
  function automatic logic [2:0] kw_len(input int k);
    logic [2:0] len;
    unique case (k)
      KW_GET:    len = 3'd3;
      KW_PUT:    len = 3'd3;
      default:   len = 3'd6;
    endcase
    return len;
  endfunction

  // Upper-case keyword letter at a given position
  function automatic logic [7:0] kw_char(input int k, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (k)
      KW_GET: begin
        unique case (idx)
          3'd0:    ch = 8'h47; // G
          3'd1:    ch = 8'h45; // E
          3'd2:    ch = 8'h54; // T
          default: ch = 8'h00;
        endcase
      end
      KW_PUT: begin
        unique case (idx)
          3'd0:    ch = 8'h50; // P
          3'd1:    ch = 8'h55; // U
          3'd2:    ch = 8'h54; // T
          default: ch = 8'h00;
        endcase
      end
      default: begin
        unique case (idx)
          3'd0:    ch = 8'h48; // H
          3'd1:    ch = 8'h45; // E
          3'd2:    ch = 8'h41; // A
          3'd3:    ch = 8'h4C; // L
          3'd4:    ch = 8'h54; // T
          3'd5:    ch = 8'h48; // H
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

  // Token separators: space, tab, LF, VT, FF, CR
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

### design/request_line_parser_top.sv
// ----------------------------------------------------------------------------
// request_line_parser_top: byte-serial request line parser
// Splits a line into tokens, matches the keyword, checks the filename and
// accumulates the decimal count; emits one result beat per line end.
// ----------------------------------------------------------------------------
// A line-end beat passes from the input register to the result register on
//   m_axis and waits while an untaken result is held. Throughput: one input beat
//   per cycle but while a line-end beat waits; the per-byte update including the
//   times-ten count step fits in the single stage between the two registers.
// Reset: rst (synchronous) empties both registers and restores parser state;
//   parser state also returns to its reset value after every line end.
module request_line_parser_top
  import rlp_pkg::*;
#(
  parameter int MAX_LINE_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] char_byte
  input  logic                s_axis_tuser,  // [0] byte_present
  input  logic                s_axis_tlast,  // line_end
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [2:0] status, [4:3] request_kind, [68:5] byte_count,
  // [80:69] name_offset, [93:81] name_length, upper bits zero
  output logic [OUT_BITS-1:0] m_axis_tdata
);

  localparam int PW = $clog2(MAX_LINE_BYTES + 1); // line position / lengths
  localparam int SW = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
  localparam logic [PW-1:0] MAX_POS = PW'(MAX_LINE_BYTES);

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_present;
  logic       s1_end;
  logic       proc;

  // Parser state
  logic [PW-1:0]     line_position,        line_position_next;
  logic [2:0]        token_number,         token_number_next;
  logic              inside_token,         inside_token_next;
  logic [PW-1:0]     current_token_length, current_token_length_next;
  logic [NUM_KW-1:0] keyword_match_flags,  keyword_match_flags_next;
  logic              name_slash,           name_slash_next;
  logic              name_dots,            name_dots_next;
  logic [SW-1:0]     name_start_reg,       name_start_reg_next;
  logic [PW-1:0]     name_len_reg,         name_len_reg_next;
  logic [63:0]       count_accumulator,    count_accumulator_next;
  logic              count_nondigit,       count_nondigit_next;
  logic              count_overflow,       count_overflow_next;

  // Result register
  logic    out_valid;
  result_t out_res;
  result_t res;

  // Handshake: a line-end beat waits while the result register is held
  assign proc          = s1_valid && (!s1_end || !out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || proc;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_BITS'(out_res);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      s1_byte    <= s_axis_tdata;
      s1_present <= s_axis_tuser;
      s1_end     <= s_axis_tlast;
    end
  end

  // Per-byte update, line-end close and result evaluation
  always_comb begin
    logic [PW-1:0]     v_pos;
    logic [2:0]        v_tok;
    logic              v_in;
    logic [PW-1:0]     v_len;
    logic [NUM_KW-1:0] v_kw;
    logic              v_slash;
    logic              v_dots;
    logic [SW-1:0]     v_start;
    logic [PW-1:0]     v_nlen;
    logic [63:0]       v_acc;
    logic              v_nd;
    logic              v_ov;
    logic [7:0]        up;
    logic [67:0]       acc10;
    kind_t             kind;
    status_t           status;
    logic [63:0]       count;

    v_pos   = line_position;
    v_tok   = token_number;
    v_in    = inside_token;
    v_len   = current_token_length;
    v_kw    = keyword_match_flags;
    v_slash = name_slash;
    v_dots  = name_dots;
    v_start = name_start_reg;
    v_nlen  = name_len_reg;
    v_acc   = count_accumulator;
    v_nd    = count_nondigit;
    v_ov    = count_overflow;
    up      = ((s1_byte >= CH_LOW_A) && (s1_byte <= CH_LOW_Z)) ?
              (s1_byte - CASE_DIFF) : s1_byte;
    acc10   = ({4'b0, count_accumulator} << 3) + ({4'b0, count_accumulator} << 1)
              + 68'(s1_byte - CH_ZERO);

    // Byte handling, ignored past the line limit
    if (s1_present && (line_position < MAX_POS)) begin
      if (is_space(s1_byte)) begin
        // close the open token
        if (v_in) begin
          if (v_tok == 3'd1) begin
            for (int k = 0; k < NUM_KW; k++) begin
              if (v_len != PW'(kw_len(k))) v_kw[k] = 1'b0;
            end
          end else if (v_tok == 3'd2) begin
            v_nlen = v_len;
          end
          v_in = 1'b0;
        end
      end else begin
        // open a new token
        if (!v_in) begin
          v_in  = 1'b1;
          v_len = '0;
          if (v_tok < 3'd4) v_tok = v_tok + 3'd1;
          if (v_tok == 3'd2) begin
            v_start = SW'(line_position);
            v_dots  = 1'b1;
          end else if (v_tok == 3'd3) begin
            v_acc = '0;
            v_nd  = 1'b0;
            v_ov  = 1'b0;
          end
        end
        // character of the current token
        if (v_tok == 3'd1) begin
          for (int k = 0; k < NUM_KW; k++) begin
            if ((v_len >= PW'(kw_len(k))) || (kw_char(k, v_len[2:0]) != up))
              v_kw[k] = 1'b0;
          end
        end else if (v_tok == 3'd2) begin
          if (s1_byte == CH_SLASH) v_slash = 1'b1;
          if (s1_byte != CH_DOT) v_dots = 1'b0;
        end else if (v_tok == 3'd3) begin
          if ((s1_byte >= CH_ZERO) && (s1_byte <= CH_NINE)) begin
            // a fresh token starts from zero, so the step value is the digit
            if (!inside_token) begin
              v_acc = 64'(s1_byte - CH_ZERO);
            end else if (acc10[67:64] != 4'd0) begin
              v_ov = 1'b1;
            end else begin
              v_acc = acc10[63:0];
            end
          end else begin
            v_nd = 1'b1;
          end
        end
        v_len = v_len + PW'(1);
      end
      v_pos = v_pos + PW'(1);
    end

    // Line end: close the last token
    if (s1_end && v_in) begin
      if (v_tok == 3'd1) begin
        for (int k = 0; k < NUM_KW; k++) begin
          if (v_len != PW'(kw_len(k))) v_kw[k] = 1'b0;
        end
      end else if (v_tok == 3'd2) begin
        v_nlen = v_len;
      end
    end

    // Keyword priority
    priority if (v_kw[KW_GET])    kind = KIND_GET;
    else if (v_kw[KW_PUT])        kind = KIND_PUT;
    else if (v_kw[KW_HEALTH])     kind = KIND_HEALTH;
    else                          kind = KIND_NONE;

    // Error checks in order
    count = '0;
    priority if (v_tok == 3'd0) begin
      status = ST_MALFORMED;
      kind   = KIND_NONE;
    end else if (kind == KIND_NONE) begin
      status = ST_UNKNOWN_TYPE;
    end else if ((kind == KIND_GET || kind == KIND_PUT) && v_tok < 3'd2) begin
      status = ST_MISSING_NAME;
    end else if ((kind == KIND_GET || kind == KIND_PUT) &&
                 (v_slash || (v_dots && v_nlen <= PW'(2)))) begin
      status = ST_INVALID_NAME;
    end else if (kind == KIND_GET) begin
      status = (v_tok >= 3'd3) ? ST_MALFORMED : ST_OK;
    end else if (kind == KIND_PUT) begin
      priority if (v_tok < 3'd3)  status = ST_MISSING_COUNT;
      else if (v_nd || v_ov)      status = ST_INVALID_COUNT;
      else if (v_tok >= 3'd4)     status = ST_MALFORMED;
      else begin
        status = ST_OK;
        count  = v_acc;
      end
    end else begin
      status = (v_tok >= 3'd2) ? ST_MALFORMED : ST_OK;
    end

    res.status       = status;
    res.request_kind = kind;
    res.byte_count   = count;
    res.name_offset  = (v_tok >= 3'd2) ? 12'(v_start) : 12'd0;
    res.name_length  = (v_tok >= 3'd2) ? 13'(v_nlen) : 13'd0;

    // Next state: back to reset values after a line end
    if (s1_end) begin
      line_position_next        = '0;
      token_number_next         = '0;
      inside_token_next         = 1'b0;
      current_token_length_next = '0;
      keyword_match_flags_next  = '1;
      name_slash_next           = 1'b0;
      name_dots_next            = 1'b0;
      name_start_reg_next       = '0;
      name_len_reg_next         = '0;
      count_accumulator_next    = '0;
      count_nondigit_next       = 1'b0;
      count_overflow_next       = 1'b0;
    end else begin
      line_position_next        = v_pos;
      token_number_next         = v_tok;
      inside_token_next         = v_in;
      current_token_length_next = v_len;
      keyword_match_flags_next  = v_kw;
      name_slash_next           = v_slash;
      name_dots_next            = v_dots;
      name_start_reg_next       = v_start;
      name_len_reg_next         = v_nlen;
      count_accumulator_next    = v_acc;
      count_nondigit_next       = v_nd;
      count_overflow_next       = v_ov;
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_position        <= '0;
      token_number         <= '0;
      inside_token         <= 1'b0;
      current_token_length <= '0;
      keyword_match_flags  <= '1;
      name_slash           <= 1'b0;
      name_dots            <= 1'b0;
      name_start_reg       <= '0;
      name_len_reg         <= '0;
      count_accumulator    <= '0;
      count_nondigit       <= 1'b0;
      count_overflow       <= 1'b0;
    end else if (proc) begin
      line_position        <= line_position_next;
      token_number         <= token_number_next;
      inside_token         <= inside_token_next;
      current_token_length <= current_token_length_next;
      keyword_match_flags  <= keyword_match_flags_next;
      name_slash           <= name_slash_next;
      name_dots            <= name_dots_next;
      name_start_reg       <= name_start_reg_next;
      name_len_reg         <= name_len_reg_next;
      count_accumulator    <= count_accumulator_next;
      count_nondigit       <= count_nondigit_next;
      count_overflow       <= count_overflow_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && s1_end) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (proc && s1_end) begin
      out_res <= res;
    end
  end

  // Token count saturates at four
  a_tok_range: assert property (@(posedge clk) disable iff (rst)
    token_number <= 3'd4)
    else $error("token counter out of range");

  // Line position never passes the limit
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    line_position <= MAX_POS)
    else $error("line position past limit");

  // An open token implies at least one token started
  a_inside_tok: assert property (@(posedge clk) disable iff (rst)
    inside_token |-> (token_number != 3'd0))
    else $error("open token with zero token count");

  // State is cleared after each line end
  a_line_clear: assert property (@(posedge clk) disable iff (rst)
    (proc && s1_end) |=> (token_number == 3'd0 && line_position == '0 && !inside_token))
    else $error("state not cleared after line end");

  // Count only reported on a good put
  a_count_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.status != ST_OK || out_res.request_kind != KIND_PUT))
      |-> (out_res.byte_count == 64'd0))
    else $error("byte count on non-put or failed result");

endmodule

### tb/tb_request_line_parser_top.sv
// ----------------------------------------------------------------------------
// tb_request_line_parser_top: stream-level test of the request line parser
// Feeds request lines byte by byte with random gaps and output stalls, keeps
// a cycle-free model of the line parser alongside, and checks each result
// beat field by field against the result predicted for that line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_request_line_parser_top;
  import rlp_pkg::*;

  localparam int LINE_LIMIT   = 4096;
  localparam int RANDOM_BYTES = 1500;

  // One input beat: the byte, its present flag and the line-end mark
  typedef struct packed {
    logic [7:0] ch;
    logic       present;
    logic       last;
  } beat_t;

  logic                clk;
  logic                rst           = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = 8'h00;  // [7:0] char_byte
  logic                s_axis_tuser  = 1'b0;   // [0] byte_present
  logic                s_axis_tlast  = 1'b0;   // line_end
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [2:0] status, [4:3] request_kind, [68:5] byte_count,
  // [80:69] name_offset, [93:81] name_length
  logic [OUT_BITS-1:0] m_axis_tdata;

  request_line_parser_top #(
    .MAX_LINE_BYTES(LINE_LIMIT)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Stimulus queue and line results still owed by the block
  beat_t   beats_todo[$];
  result_t line_results_due[$];

  int unsigned err_count       = 0;
  int unsigned lines_queued    = 0;
  int unsigned bytes_queued    = 0;
  int unsigned line_beats      = 0;
  int unsigned beats_accepted  = 0;
  int unsigned results_checked = 0;
  int unsigned status_hits[8];

  // Parser model state for the line in progress
  logic [12:0] ln_pos;
  logic [2:0]  tok_count;
  logic        in_token;
  logic [12:0] tok_len;
  logic [2:0]  kw_alive;
  logic        nm_slash;
  logic        nm_dots;
  logic [11:0] nm_start;
  logic [12:0] nm_len;
  logic [63:0] cnt_acc;
  logic        cnt_nondigit;
  logic        cnt_overflow;

  // Idle pattern control for both sides
  int unsigned tx_wait = 0, tx_phase = 0, rx_wait = 0, rx_phase = 0;
  bit          tx_calm = 1'b0, rx_calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("request_line_parser_top test failed");
    $finish;
  end

  function automatic string kw_spelling(input int k);
    case (k)
      KW_GET:  return "GET";
      KW_PUT:  return "PUT";
      default: return "HEALTH";
    endcase
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Mostly short gaps, a few long ones, none at all in calm phases
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Line parser model
  // ---------------------------------------------------------------------------
  task automatic clear_line_state();
    ln_pos       = '0;
    tok_count    = '0;
    in_token     = 1'b0;
    tok_len      = '0;
    kw_alive     = 3'b111;
    nm_slash     = 1'b0;
    nm_dots      = 1'b0;
    nm_start     = '0;
    nm_len       = '0;
    cnt_acc      = '0;
    cnt_nondigit = 1'b0;
    cnt_overflow = 1'b0;
  endtask

  task automatic end_token();
    if (in_token) begin
      if (tok_count == 3'd1) begin
        for (int k = 0; k < NUM_KW; k++)
          if (kw_spelling(k).len() != tok_len) kw_alive[k] = 1'b0;
      end else if (tok_count == 3'd2) begin
        nm_len = tok_len;
      end
      in_token = 1'b0;
    end
  endtask

  task automatic absorb_token_byte(input logic [7:0] c);
    logic [7:0]  up;
    logic [63:0] digit;
    string       w;
    if (tok_count == 3'd1) begin
      up = (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_DIFF : c;
      for (int k = 0; k < NUM_KW; k++) begin
        w = kw_spelling(k);
        if (tok_len >= w.len() || 8'(w[tok_len]) != up) kw_alive[k] = 1'b0;
      end
    end else if (tok_count == 3'd2) begin
      if (c == CH_SLASH) nm_slash = 1'b1;
      if (c != CH_DOT) nm_dots = 1'b0;
    end else if (tok_count == 3'd3) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        digit = 64'(c - CH_ZERO);
        if (cnt_acc > (64'hFFFF_FFFF_FFFF_FFFF - digit) / 64'd10)
          cnt_overflow = 1'b1;
        else
          cnt_acc = cnt_acc * 64'd10 + digit;
      end else begin
        cnt_nondigit = 1'b1;
      end
    end
    tok_len = tok_len + 13'd1;
  endtask

  // Advance the model by one accepted beat; a line end owes one result
  task automatic follow_line_beat(input logic [7:0] c, input logic present,
                                  input logic last);
    result_t res;
    kind_t   kind;
    status_t st;
    if (present && ln_pos < LINE_LIMIT) begin
      if (is_blank(c)) begin
        end_token();
      end else begin
        if (!in_token) begin
          in_token = 1'b1;
          tok_len  = '0;
          if (tok_count < 3'd4) tok_count = tok_count + 3'd1;
          if (tok_count == 3'd2) begin
            nm_start = ln_pos[11:0];
            nm_slash = 1'b0;
            nm_dots  = 1'b1;
          end else if (tok_count == 3'd3) begin
            cnt_acc      = '0;
            cnt_nondigit = 1'b0;
            cnt_overflow = 1'b0;
          end
        end
        absorb_token_byte(c);
      end
      ln_pos = ln_pos + 13'd1;
    end
    if (last) begin
      end_token();
      res  = '0;
      kind = KIND_NONE;
      if (kw_alive[KW_GET])         kind = KIND_GET;
      else if (kw_alive[KW_PUT])    kind = KIND_PUT;
      else if (kw_alive[KW_HEALTH]) kind = KIND_HEALTH;

      // error checks in priority order
      if (tok_count == 3'd0) begin
        st   = ST_MALFORMED;
        kind = KIND_NONE;
      end else if (kind == KIND_NONE) begin
        st = ST_UNKNOWN_TYPE;
      end else if ((kind == KIND_GET || kind == KIND_PUT) && tok_count < 3'd2) begin
        st = ST_MISSING_NAME;
      end else if ((kind == KIND_GET || kind == KIND_PUT) &&
                   (nm_slash || (nm_dots && nm_len <= 13'd2))) begin
        st = ST_INVALID_NAME;
      end else if (kind == KIND_GET) begin
        st = (tok_count >= 3'd3) ? ST_MALFORMED : ST_OK;
      end else if (kind == KIND_PUT) begin
        if (tok_count < 3'd3)                 st = ST_MISSING_COUNT;
        else if (cnt_nondigit || cnt_overflow) st = ST_INVALID_COUNT;
        else if (tok_count >= 3'd4)           st = ST_MALFORMED;
        else begin
          st             = ST_OK;
          res.byte_count = cnt_acc;
        end
      end else begin
        st = (tok_count >= 3'd2) ? ST_MALFORMED : ST_OK;
      end
      res.status       = st;
      res.request_kind = kind;
      if (tok_count >= 3'd2) begin
        res.name_offset = nm_start;
        res.name_length = nm_len;
      end
      line_results_due.push_back(res);
      clear_line_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Line building
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] random_token_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_blank(c));
    return c;
  endfunction

  task automatic push_marker(input logic last);
    beat_t b;
    b.ch      = 8'($urandom_range(0, 255));
    b.present = 1'b0;
    b.last    = last;
    beats_todo.push_back(b);
    line_beats++;
  endtask

  task automatic push_byte(input logic [7:0] c);
    beat_t b;
    if ($urandom_range(0, 24) == 0) push_marker(1'b0);
    b.ch      = c;
    b.present = 1'b1;
    b.last    = 1'b0;
    beats_todo.push_back(b);
    line_beats++;
    bytes_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(8'(s[i]));
  endtask

  task automatic push_run(input logic [7:0] c, input int unsigned n);
    repeat (n) push_byte(c);
  endtask

  // Mark the line end on the last beat, or on an extra empty beat
  task automatic finish_line();
    beat_t b;
    if (line_beats == 0 || $urandom_range(0, 3) == 0) begin
      push_marker(1'b1);
    end else begin
      b      = beats_todo.pop_back();
      b.last = 1'b1;
      beats_todo.push_back(b);
    end
    line_beats = 0;
    lines_queued++;
  endtask

  task automatic push_line(input string s);
    push_text(s);
    finish_line();
  endtask

  task automatic push_blanks();
    int unsigned r;
    repeat ($urandom_range(1, 3)) begin
      r = $urandom_range(0, 9);
      if (r < 5) push_byte(CH_SPACE);
      else if (r < 6) push_byte(CH_TAB);
      else push_byte(8'($urandom_range(9, 13)));
    end
  endtask

  // Keyword in random letter case, optionally damaged
  task automatic push_keyword(input int k, input bit damage);
    string       w;
    int unsigned n, bad_at, how;
    logic [7:0]  c;
    w      = kw_spelling(k);
    n      = w.len();
    bad_at = n;
    how    = $urandom_range(0, 2);
    if (damage && how == 0) n = $urandom_range(1, n - 1);
    if (damage && how == 2) bad_at = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      c = (i == bad_at) ? random_token_byte() : 8'(w[i]);
      if (c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1)) c = c + CASE_DIFF;
      push_byte(c);
    end
    if (damage && how == 1) push_byte(8'h41 + 8'($urandom_range(0, 25)));
  endtask

  task automatic push_filename();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8)       push_text(".");
    else if (r < 16) push_text("..");
    else if (r < 20) push_text("...");
    else begin
      repeat ($urandom_range(1, 12)) begin
        r = $urandom_range(0, 99);
        if (r < 50)      push_byte(CH_LOW_A + 8'($urandom_range(0, 25)));
        else if (r < 65) push_byte(8'h41 + 8'($urandom_range(0, 25)));
        else if (r < 75) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        else if (r < 85) push_byte(CH_DOT);
        else if (r < 90) push_byte(CH_SLASH);
        else             push_byte(random_token_byte());
      end
    end
  endtask

  task automatic push_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      repeat ($urandom_range(1, 19)) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    end else if (r < 80) begin
      // around the 64-bit limit: last digit 0..5 fits, 6..9 overflows
      push_text("1844674407370955161");
      push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    end else if (r < 88) begin
      repeat ($urandom_range(21, 25)) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    end else if (r < 94) begin
      push_run(CH_ZERO, $urandom_range(1, 6));
      repeat ($urandom_range(0, 8)) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    end else begin
      repeat ($urandom_range(0, 4)) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
      push_byte(random_token_byte());
      repeat ($urandom_range(0, 4)) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic push_stray_tokens();
    repeat ($urandom_range(1, 2)) begin
      push_blanks();
      repeat ($urandom_range(1, 6)) push_byte(random_token_byte());
    end
  endtask

  // Mostly well-formed requests with random content, some noise
  task automatic add_random_line();
    int unsigned r, k;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      repeat ($urandom_range(0, 2)) push_blanks();
    end else if (r < 12) begin
      repeat ($urandom_range(1, 24)) push_byte(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) push_blanks();
      k = $urandom_range(0, 9);
      if (k < 3) begin
        push_keyword(KW_GET, 1'b0);
        if ($urandom_range(0, 99) < 92) begin push_blanks(); push_filename(); end
        if ($urandom_range(0, 99) < 8) push_stray_tokens();
      end else if (k < 6) begin
        push_keyword(KW_PUT, 1'b0);
        if ($urandom_range(0, 99) < 94) begin
          push_blanks();
          push_filename();
          if ($urandom_range(0, 99) < 90) begin push_blanks(); push_count(); end
        end
        if ($urandom_range(0, 99) < 8) push_stray_tokens();
      end else if (k < 8) begin
        push_keyword(KW_HEALTH, 1'b0);
        if ($urandom_range(0, 99) < 15) push_stray_tokens();
      end else begin
        push_keyword($urandom_range(0, NUM_KW - 1), 1'b1);
        if ($urandom_range(0, 99) < 70) begin push_blanks(); push_filename(); end
        if ($urandom_range(0, 99) < 30) begin push_blanks(); push_count(); end
      end
      if ($urandom_range(0, 99) < 30) push_blanks();
    end
    finish_line();
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: one beat from the queue per handshake, random gaps between
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : tx_drive
    beat_t b;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        follow_line_beat(s_axis_tdata, s_axis_tuser, s_axis_tlast);
        beats_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (beats_todo.size() > 0) begin
          b = beats_todo.pop_front();
          s_axis_tdata  <= b.ch;
          s_axis_tuser  <= b.present;
          s_axis_tlast  <= b.last;
          s_axis_tvalid <= 1'b1;
          if (tx_phase == 0) begin
            tx_calm  = ($urandom_range(0, 3) == 0);
            tx_phase = $urandom_range(30, 300);
          end else begin
            tx_phase--;
          end
          tx_wait = pick_gap(tx_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: compare each result beat, stall the receiver at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : rx_check
    result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[RESULT_BITS-1:0];
      if (line_results_due.size() == 0) begin
        $error("result beat with no line end pending: %h", m_axis_tdata);
        err_count++;
      end else begin
        want = line_results_due.pop_front();
        results_checked++;
        status_hits[want.status]++;
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          err_count++;
        end
        if (got.request_kind !== want.request_kind) begin
          $error("request_kind: expected %0d, got %0d", want.request_kind,
                 got.request_kind);
          err_count++;
        end
        if (got.byte_count !== want.byte_count) begin
          $error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
          err_count++;
        end
        if (got.name_offset !== want.name_offset) begin
          $error("name_offset: expected %0d, got %0d", want.name_offset,
                 got.name_offset);
          err_count++;
        end
        if (got.name_length !== want.name_length) begin
          $error("name_length: expected %0d, got %0d", want.name_length,
                 got.name_length);
          err_count++;
        end
      end
    end
    if (rx_wait > 0) begin
      rx_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (rx_phase == 0) begin
        rx_calm  = ($urandom_range(0, 3) == 0);
        rx_phase = $urandom_range(30, 300);
      end else begin
        rx_phase--;
      end
      rx_wait = pick_gap(rx_calm);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned random_from;
    clear_line_state();
    foreach (status_hits[i]) status_hits[i] = 0;

    // directed lines: each keyword, each error, count limits
    push_line("GET index.html");
    push_line("put data.bin 12345");
    push_line("HEALTH");
    push_line("");
    push_line("  \t\015\n\v\f ");
    push_line("FETCH x");
    push_line("gEt");
    push_line("PUT");
    push_line("GET a/b");
    push_line("GET .");
    push_line("PUT .. 5");
    push_line("GET ...");
    push_line("PUT f");
    push_line("PUT f 12a");
    push_line("PUT f 18446744073709551615");
    push_line("PUT f 18446744073709551616");
    push_line("pUt f 000042");
    push_line("GET f extra");
    push_line("PUT f 5 x y z");
    push_line("health now");
    push_line("HEALTHY");
    push_line("\307ET f");
    push_line("GET \377\200\t");

    // name far into the line, then a name running past the line limit
    push_text("PUT");
    push_run(CH_TAB, 1536);
    push_line("f 7");
    push_text("GET ");
    push_run(8'h71, 4092);
    push_line(" more tokens past the limit");
    push_text("get");
    push_run(CH_SPACE, 3000);
    push_text("ab/c");
    push_run(8'h78, 1200);
    finish_line();

    // random requests
    random_from = bytes_queued;
    while (bytes_queued - random_from < RANDOM_BYTES) add_random_line();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (beats_todo.size() != 0 || s_axis_tvalid || line_results_due.size() != 0)
      @(negedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d request lines in %0d beats, %0d results compared.",
             lines_queued, beats_accepted, results_checked);
    $display("Status mix: ok %0d, malformed %0d, unknown %0d, no name %0d, bad name %0d, no count %0d, bad count %0d",
             status_hits[ST_OK], status_hits[ST_MALFORMED],
             status_hits[ST_UNKNOWN_TYPE], status_hits[ST_MISSING_NAME],
             status_hits[ST_INVALID_NAME], status_hits[ST_MISSING_COUNT],
             status_hits[ST_INVALID_COUNT]);
    if (err_count == 0 && line_results_due.size() == 0) begin
      $display("request_line_parser_top test passed");
    end else begin
      $display("request_line_parser_top test failed");
    end
    $finish;
  end

endmodule
